/* sv/quaternion_slerp_defines.svh */
// Assertion macros used by quaternion_slerp.
// No dependencies; ASSERT_OFF empties every macro.
`ifndef QUATERNION_SLERP_DEFINES_SVH
`define QUATERNION_SLERP_DEFINES_SVH
`ifndef ASSERT_OFF
// clocked assertion, quiet while reset is held
`define SLRP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked assertion, checked through reset too
`define SLRP_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLRP_ASSERT(label, clk, rst_n, prop, msg)
`define SLRP_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* sv/slrp_pkg.sv */
// Shared types and constants for the quaternion slerp pipeline.
// No dependencies.
package slrp_pkg;

  localparam int ANG_BITS     = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 31;
  localparam int DIV_STEPS    = 32;
  localparam logic [29:0] CORDIC_INV_GAIN = 30'd652032874;

  typedef logic signed [31:0] comp_t;
  typedef comp_t [3:0] quat_t;

  // atan(2^-i) in Q.30 radians
  function automatic logic [29:0] atan_step(input int i);
    logic [29:0] a;
    case (i)
      0: a = 30'd843314857;
      1: a = 30'd497837829;
      2: a = 30'd263043837;
      3: a = 30'd133525159;
      4: a = 30'd67021687;
      5: a = 30'd33543516;
      6: a = 30'd16775851;
      7: a = 30'd8388437;
      8: a = 30'd4194283;
      9: a = 30'd2097149;
      default: a = 30'(64'd1 << (ANG_BITS - i));
    endcase
    return a;
  endfunction

  // sideband through the square root
  typedef struct packed {
    quat_t       from;
    quat_t       to;
    logic [16:0] t;
    logic        neg;
    logic        near;
    logic [30:0] d30;
  } sq_side_t;

  // sideband through the angle CORDIC
  typedef struct packed {
    quat_t       from;
    quat_t       to;
    logic [16:0] t;
    logic        neg;
    logic        near;
    logic [30:0] sinth;
  } vec_side_t;

  // sideband through the sine CORDIC
  typedef struct packed {
    quat_t       from;
    quat_t       to;
    logic        neg;
    logic        near;
    logic [30:0] sinth;
  } sin_side_t;

  // sideband through the divider
  typedef struct packed {
    logic  near;
    quat_t near_q;
  } div_side_t;

  // one divider lane result
  typedef struct packed {
    logic        ovf;
    logic        neg;
    logic [31:0] quo;
  } div_res_t;

endpackage

/* sv/slrp_isqrt.sv */
// Pipelined floor square root, one result bit per stage.
// Depends on slrp_pkg.
module slrp_isqrt #(
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [60:0]     in_rad,
  input  logic [SB_W-1:0] in_side,
  output logic            out_valid,
  output logic [30:0]     out_root,
  output logic [SB_W-1:0] out_side
);
  import slrp_pkg::*;

  localparam int NS = SQRT_STEPS;

  logic [61:0]     rem_r  [NS];
  logic [30:0]     root_r [NS];
  logic            v_r    [NS];
  logic [SB_W-1:0] sb_r   [NS];

  genvar k;
  for (k = 0; k < NS; k++) begin : g_stage
    localparam int B = NS - 1 - k;
    logic [61:0]     rem_c, trial, rem_nxt;
    logic [30:0]     root_c, root_nxt;
    logic            v_c;
    logic [SB_W-1:0] sb_c;

    if (k == 0) begin : g_first
      assign rem_c  = {1'b0, in_rad};
      assign root_c = '0;
      assign v_c    = in_valid;
      assign sb_c   = in_side;
    end else begin : g_next
      assign rem_c  = rem_r[k-1];
      assign root_c = root_r[k-1];
      assign v_c    = v_r[k-1];
      assign sb_c   = sb_r[k-1];
    end

    // try setting result bit B
    always_comb begin
      trial = ({31'd0, root_c} << (B + 1)) | (62'd1 << (2 * B));
      if (rem_c >= trial) begin
        rem_nxt  = rem_c - trial;
        root_nxt = root_c | (31'd1 << B);
      end else begin
        rem_nxt  = rem_c;
        root_nxt = root_c;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        sb_r[k]   <= sb_c;
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_root  = root_r[NS-1];
  assign out_side  = sb_r[NS-1];

endmodule

/* sv/slrp_cordic_vec.sv */
// Pipelined CORDIC in vectoring mode: angle of (x, y) in Q.30 radians.
// Depends on slrp_pkg.
module slrp_cordic_vec #(
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [30:0]     in_x,
  input  logic [30:0]     in_y,
  input  logic [SB_W-1:0] in_side,
  output logic            out_valid,
  output logic [30:0]     out_theta,
  output logic [SB_W-1:0] out_side
);
  import slrp_pkg::*;

  localparam int NS = CORDIC_STEPS;

  logic signed [33:0] x_r [NS];
  logic signed [33:0] y_r [NS];
  logic signed [32:0] z_r [NS];
  logic               v_r [NS];
  logic [SB_W-1:0]    sb_r [NS];

  genvar k;
  for (k = 0; k < NS; k++) begin : g_stage
    localparam logic signed [32:0] ATAN = 33'(atan_step(k));
    logic signed [33:0] x_c, y_c, x_nxt, y_nxt;
    logic signed [32:0] z_c, z_nxt;
    logic               v_c;
    logic [SB_W-1:0]    sb_c;

    if (k == 0) begin : g_first
      assign x_c  = $signed({3'b000, in_x});
      assign y_c  = $signed({3'b000, in_y});
      assign z_c  = '0;
      assign v_c  = in_valid;
      assign sb_c = in_side;
    end else begin : g_next
      assign x_c  = x_r[k-1];
      assign y_c  = y_r[k-1];
      assign z_c  = z_r[k-1];
      assign v_c  = v_r[k-1];
      assign sb_c = sb_r[k-1];
    end

    // rotate toward the x axis
    always_comb begin
      if (y_c >= 0) begin
        x_nxt = x_c + (y_c >>> k);
        y_nxt = y_c - (x_c >>> k);
        z_nxt = z_c + ATAN;
      end else begin
        x_nxt = x_c - (y_c >>> k);
        y_nxt = y_c + (x_c >>> k);
        z_nxt = z_c - ATAN;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]  <= x_nxt;
        y_r[k]  <= y_nxt;
        z_r[k]  <= z_nxt;
        sb_r[k] <= sb_c;
      end
    end
  end

  // clamp negative angles to zero
  logic            vo_r;
  logic [30:0]     theta_r, theta_nxt;
  logic [SB_W-1:0] so_r;

  always_comb begin
    if (z_r[NS-1] < 0) begin
      theta_nxt = '0;
    end else begin
      theta_nxt = z_r[NS-1][30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      theta_r <= theta_nxt;
      so_r    <= sb_r[NS-1];
    end
  end

  assign out_valid = vo_r;
  assign out_theta = theta_r;
  assign out_side  = so_r;

endmodule

/* sv/slrp_cordic_sin.sv */
// Two-lane pipelined CORDIC in rotation mode, sine of each angle in Q.30.
// Depends on slrp_pkg.
module slrp_cordic_sin #(
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [30:0]     in_z0,
  input  logic [30:0]     in_z1,
  input  logic [SB_W-1:0] in_side,
  output logic            out_valid,
  output logic [30:0]     out_s0,
  output logic [30:0]     out_s1,
  output logic [SB_W-1:0] out_side
);
  import slrp_pkg::*;

  localparam int NS = CORDIC_STEPS;
  localparam logic signed [33:0] S_ONE = 34'sd1 <<< ANG_BITS;

  logic signed [33:0] x_r [2][NS];
  logic signed [33:0] y_r [2][NS];
  logic signed [32:0] z_r [2][NS];
  logic               v_r [NS];
  logic [SB_W-1:0]    sb_r [NS];
  logic [30:0]        s_r [2];
  logic [30:0]        lane_z [2];

  assign lane_z[0] = in_z0;
  assign lane_z[1] = in_z1;

  genvar k, l;
  for (k = 0; k < NS; k++) begin : g_ctl
    logic            v_c;
    logic [SB_W-1:0] sb_c;
    if (k == 0) begin : g_first
      assign v_c  = in_valid;
      assign sb_c = in_side;
    end else begin : g_next
      assign v_c  = v_r[k-1];
      assign sb_c = sb_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[k] <= sb_c;
      end
    end
  end

  for (l = 0; l < 2; l++) begin : g_lane
    for (k = 0; k < NS; k++) begin : g_stage
      localparam logic signed [32:0] ATAN = 33'(atan_step(k));
      logic signed [33:0] x_c, y_c, x_nxt, y_nxt;
      logic signed [32:0] z_c, z_nxt;

      if (k == 0) begin : g_first
        assign x_c = $signed({4'b0000, CORDIC_INV_GAIN});
        assign y_c = '0;
        assign z_c = $signed({2'b00, lane_z[l]});
      end else begin : g_next
        assign x_c = x_r[l][k-1];
        assign y_c = y_r[l][k-1];
        assign z_c = z_r[l][k-1];
      end

      // rotate by the remaining angle
      always_comb begin
        if (z_c >= 0) begin
          x_nxt = x_c - (y_c >>> k);
          y_nxt = y_c + (x_c >>> k);
          z_nxt = z_c - ATAN;
        end else begin
          x_nxt = x_c + (y_c >>> k);
          y_nxt = y_c - (x_c >>> k);
          z_nxt = z_c + ATAN;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          x_r[l][k] <= x_nxt;
          y_r[l][k] <= y_nxt;
          z_r[l][k] <= z_nxt;
        end
      end
    end

    // clamp the sine to [0, 1.0]
    logic [30:0] s_nxt;
    always_comb begin
      if (y_r[l][NS-1] < 0) begin
        s_nxt = '0;
      end else if (y_r[l][NS-1] > S_ONE) begin
        s_nxt = S_ONE[30:0];
      end else begin
        s_nxt = y_r[l][NS-1][30:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[l] <= s_nxt;
      end
    end
  end

  logic            vo_r;
  logic [SB_W-1:0] so_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      so_r <= sb_r[NS-1];
    end
  end

  assign out_valid = vo_r;
  assign out_s0    = s_r[0];
  assign out_s1    = s_r[1];
  assign out_side  = so_r;

endmodule

/* sv/slrp_div.sv */
// Four-lane pipelined signed divider, one quotient bit per stage,
// truncating toward zero with an overflow flag. Depends on slrp_pkg.
module slrp_div #(
  parameter int SB_W = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [3:0][63:0]       in_num,
  input  logic [30:0]            in_den,
  input  logic [SB_W-1:0]        in_side,
  output logic                   out_valid,
  output slrp_pkg::div_res_t [3:0] out_res,
  output logic [SB_W-1:0]        out_side
);
  import slrp_pkg::*;

  localparam int NS = DIV_STEPS;

  // stage 0 takes magnitudes, stages 1..NS make quotient bits
  logic [63:0]     rem_r [4][NS+1];
  logic [31:0]     q_r   [4][NS+1];
  logic            ovf_r [4][NS+1];
  logic            neg_r [4][NS+1];
  logic [30:0]     den_r [NS+1];
  logic            v_r   [NS+1];
  logic [SB_W-1:0] sb_r  [NS+1];

  genvar k, l;
  for (k = 0; k <= NS; k++) begin : g_ctl
    logic            v_c;
    logic [SB_W-1:0] sb_c;
    logic [30:0]     den_c;
    if (k == 0) begin : g_first
      assign v_c   = in_valid;
      assign sb_c  = in_side;
      assign den_c = in_den;
    end else begin : g_next
      assign v_c   = v_r[k-1];
      assign sb_c  = sb_r[k-1];
      assign den_c = den_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[k]  <= sb_c;
        den_r[k] <= den_c;
      end
    end
  end

  for (l = 0; l < 4; l++) begin : g_lane
    // magnitude, sign and overflow check
    logic        neg0, ovf0;
    logic [63:0] mag0;
    always_comb begin
      neg0 = in_num[l][63];
      mag0 = neg0 ? (64'd0 - in_num[l]) : in_num[l];
      ovf0 = (mag0[63:32] >= {1'b0, in_den});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[l][0] <= mag0;
        q_r[l][0]   <= '0;
        ovf_r[l][0] <= ovf0;
        neg_r[l][0] <= neg0;
      end
    end

    for (k = 1; k <= NS; k++) begin : g_stage
      localparam int B = NS - k;
      logic [63:0] trial, rem_nxt;
      logic [31:0] q_nxt;

      always_comb begin
        trial = {33'd0, den_r[k-1]} << B;
        if (rem_r[l][k-1] >= trial) begin
          rem_nxt = rem_r[l][k-1] - trial;
          q_nxt   = q_r[l][k-1] | (32'd1 << B);
        end else begin
          rem_nxt = rem_r[l][k-1];
          q_nxt   = q_r[l][k-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[l][k] <= rem_nxt;
          q_r[l][k]   <= q_nxt;
          ovf_r[l][k] <= ovf_r[l][k-1];
          neg_r[l][k] <= neg_r[l][k-1];
        end
      end
    end

    assign out_res[l].ovf = ovf_r[l][NS];
    assign out_res[l].neg = neg_r[l][NS];
    assign out_res[l].quo = q_r[l][NS];
  end

  assign out_valid = v_r[NS];
  assign out_side  = sb_r[NS];

endmodule

/* sv/quaternion_slerp.sv */
// Shortest-path slerp of two unit quaternions (Q2.30) at fraction t (Q1.16).
// Fully pipelined: one item is taken every clock while no result waits at a
// stalled output. The pipe runs through the dot product and d^2, the
// bit-per-stage square root giving sin(theta), the angle CORDIC, t*theta, the
// dual sine CORDIC, the weighted sum, the bit-per-stage divider and the output
// register. The whole pipe holds while a result waits at a stalled output.
// Near-equal inputs pass the start quaternion through; all outputs saturate
// to +/-1.0.
// Depends on slrp_pkg, slrp_isqrt, slrp_cordic_vec, slrp_cordic_sin, slrp_div.
`include "quaternion_slerp_defines.svh"
module quaternion_slerp #(
  parameter int COMPONENT_FRAC_BITS = 30,
  parameter int FRACTION_BITS       = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // from_x, from_y, from_z, from_w, to_x, to_y, to_z, to_w, interp_t, pad
  input  logic [279:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x, out_y, out_z, out_w
  output logic [127:0] out_tdata
);
  import slrp_pkg::*;

  localparam int F  = COMPONENT_FRAC_BITS;
  localparam int FB = FRACTION_BITS;
  localparam int TW = (FB + 1 > 17) ? FB + 1 : 17;
  localparam logic signed [31:0] ONE_Q  = 32'(64'd1 << F);
  localparam logic signed [63:0] ONE_W  = 64'(64'd1 << F);
  localparam logic [TW-1:0]      T_MAX  = TW'(64'd1 << FB);
  localparam logic [61:0]        RAD_1  = 62'd1 << (2 * ANG_BITS);
  localparam int SQ_W  = $bits(sq_side_t);
  localparam int VEC_W = $bits(vec_side_t);
  localparam int SIN_W = $bits(sin_side_t);
  localparam int DIV_W = $bits(div_side_t);

  function automatic logic [31:0] sat_q(input logic signed [31:0] v);
    logic [31:0] r;
    if (v > ONE_Q) begin
      r = ONE_Q;
    end else if (v < -ONE_Q) begin
      r = -ONE_Q;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // global advance: the pipe moves unless a result is stuck at the output
  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // input unpack
  quat_t       from_in, to_in;
  logic [16:0] t_in;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      from_in[k] = in_tdata[32*k +: 32];
      to_in[k]   = in_tdata[128 + 32*k +: 32];
    end
    t_in = in_tdata[272:256];
  end

  // stage 1: component products, floored to Q.F
  logic                     v1_r;
  logic signed [3:0][63:0]  p1_r;
  logic signed [3:0][63:0]  p1_nxt;
  quat_t                    from1_r, to1_r;
  logic [16:0]              t1_r;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic signed [63:0] prod;
      prod      = $signed(from_in[k]) * $signed(to_in[k]);
      p1_nxt[k] = prod >>> F;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r    <= p1_nxt;
      from1_r <= from_in;
      to1_r   <= to_in;
      t1_r    <= t_in;
    end
  end

  // stage 2: dot sum, |dot| saturated, near-equal test
  logic               v2_r, neg2_r, near2_r;
  logic [30:0]        d30_2_r;
  quat_t              from2_r, to2_r;
  logic [16:0]        t2_r;
  logic signed [63:0] dot_c, adot_c;
  always_comb begin
    dot_c  = $signed(p1_r[0]) + $signed(p1_r[1]) + $signed(p1_r[2]) + $signed(p1_r[3]);
    adot_c = (dot_c < 0) ? -dot_c : dot_c;
    if (adot_c > ONE_W) begin
      adot_c = ONE_W;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg2_r  <= dot_c < 0;
      near2_r <= adot_c >= (ONE_W - 64'sd1);
      d30_2_r <= 31'(adot_c << (ANG_BITS - F));
      from2_r <= from1_r;
      to2_r   <= to1_r;
      t2_r    <= t1_r;
    end
  end

  // stage 3: radicand 1 - d^2 in Q.60
  logic        v3_r;
  logic [60:0] rad3_r;
  sq_side_t    side3_r;
  logic [61:0] dsq_c;
  assign dsq_c = d30_2_r * d30_2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad3_r       <= 61'(RAD_1 - dsq_c);
      side3_r.from <= from2_r;
      side3_r.to   <= to2_r;
      side3_r.t    <= t2_r;
      side3_r.neg  <= neg2_r;
      side3_r.near <= near2_r;
      side3_r.d30  <= d30_2_r;
    end
  end

  // sin(theta) by square root
  logic            sq_v;
  logic [30:0]     sinth_w;
  logic [SQ_W-1:0] sq_sb;
  sq_side_t        sq_s;

  slrp_isqrt #(.SB_W(SQ_W)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v3_r),
    .in_rad   (rad3_r),
    .in_side  (SQ_W'(side3_r)),
    .out_valid(sq_v),
    .out_root (sinth_w),
    .out_side (sq_sb)
  );
  assign sq_s = sq_side_t'(sq_sb);

  // theta = atan2(sin, d)
  vec_side_t        vec_in_s, vec_s;
  logic             vec_v;
  logic [30:0]      theta_w;
  logic [VEC_W-1:0] vec_sb;
  always_comb begin
    vec_in_s.from  = sq_s.from;
    vec_in_s.to    = sq_s.to;
    vec_in_s.t     = sq_s.t;
    vec_in_s.neg   = sq_s.neg;
    vec_in_s.near  = sq_s.near || (sinth_w == 31'd0);
    vec_in_s.sinth = sinth_w;
  end

  slrp_cordic_vec #(.SB_W(VEC_W)) u_vec (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (sq_v),
    .in_x     (sq_s.d30),
    .in_y     (sinth_w),
    .in_side  (VEC_W'(vec_in_s)),
    .out_valid(vec_v),
    .out_theta(theta_w),
    .out_side (vec_sb)
  );
  assign vec_s = vec_side_t'(vec_sb);

  // stage 5: a1 = theta * t
  logic             v5_r;
  logic [30:0]      theta5_r, a1_5_r;
  sin_side_t        side5_r;
  logic [TW-1:0]    t_eff;
  logic [TW+30:0]   ta_c;
  always_comb begin
    t_eff = TW'(vec_s.t);
    if (t_eff > T_MAX) begin
      t_eff = T_MAX;
    end
    ta_c = theta_w * t_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= vec_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      theta5_r      <= theta_w;
      a1_5_r        <= 31'(ta_c >> FB);
      side5_r.from  <= vec_s.from;
      side5_r.to    <= vec_s.to;
      side5_r.neg   <= vec_s.neg;
      side5_r.near  <= vec_s.near;
      side5_r.sinth <= vec_s.sinth;
    end
  end

  // sines of a0 = theta - a1 and a1
  logic             sin_v;
  logic [30:0]      s0_w, s1_w;
  logic [SIN_W-1:0] sin_sb;
  sin_side_t        sin_s;

  slrp_cordic_sin #(.SB_W(SIN_W)) u_sin (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v5_r),
    .in_z0    (theta5_r - a1_5_r),
    .in_z1    (a1_5_r),
    .in_side  (SIN_W'(side5_r)),
    .out_valid(sin_v),
    .out_s0   (s0_w),
    .out_s1   (s1_w),
    .out_side (sin_sb)
  );
  assign sin_s = sin_side_t'(sin_sb);

  // stage 7: weight products
  logic                    v7_r;
  logic signed [3:0][63:0] mf7_r, mt7_r;
  logic signed [3:0][63:0] mf_c, mt_c;
  sin_side_t               side7_r;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mf_c[k] = $signed(sin_s.from[k]) * $signed({1'b0, s0_w});
      mt_c[k] = $signed(sin_s.to[k]) * $signed({1'b0, s1_w});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= sin_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mf7_r   <= mf_c;
      mt7_r   <= mt_c;
      side7_r <= sin_s;
    end
  end

  // stage 8: numerators, near-equal fallback values
  logic              v8_r;
  logic [3:0][63:0]  num8_r, num_c;
  logic [30:0]       den8_r;
  div_side_t         dside8_r, dside_c;
  always_comb begin
    dside_c.near = side7_r.near;
    for (int k = 0; k < 4; k++) begin
      num_c[k] = side7_r.neg ? ($signed(mf7_r[k]) - $signed(mt7_r[k]))
                             : ($signed(mf7_r[k]) + $signed(mt7_r[k]));
      dside_c.near_q[k] = sat_q($signed(side7_r.from[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (en) begin
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num8_r   <= num_c;
      den8_r   <= side7_r.sinth;
      dside8_r <= dside_c;
    end
  end

  // divide by sin(theta)
  logic             div_v;
  div_res_t [3:0]   div_res;
  logic [DIV_W-1:0] div_sb;
  div_side_t        div_s;

  slrp_div #(.SB_W(DIV_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v8_r),
    .in_num   (num8_r),
    .in_den   (den8_r),
    .in_side  (DIV_W'(dside8_r)),
    .out_valid(div_v),
    .out_res  (div_res),
    .out_side (div_sb)
  );
  assign div_s = div_side_t'(div_sb);

  // output register: saturate quotient or pass the start quaternion
  logic [127:0] out_data_r, out_data_nxt;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [31:0] mag;
      if (div_res[k].ovf || ({1'b0, div_res[k].quo} > {1'b0, ONE_Q})) begin
        mag = ONE_Q;
      end else begin
        mag = div_res[k].quo;
      end
      if (div_s.near) begin
        out_data_nxt[32*k +: 32] = div_s.near_q[k];
      end else begin
        out_data_nxt[32*k +: 32] = div_res[k].neg ? (32'd0 - mag) : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `SLRP_ASSERT(a_stall_cause, clk, rst_n, !in_tready |-> (out_tvalid && !out_tready), "input held without a blocked output")
  `SLRP_ASSERT(a_hold_pipe, clk, rst_n, !en |=> ($stable(num8_r) && $stable(v8_r)), "pipeline moved during a stall")
  `SLRP_ASSERT(a_div_den, clk, rst_n, (v8_r && !dside8_r.near) |-> (den8_r != 31'd0), "zero divisor on a divided item")
  `SLRP_ASSERT(a_out_range, clk, rst_n, out_tvalid |-> (($signed(out_tdata[31:0]) <= ONE_Q) && ($signed(out_tdata[31:0]) >= -ONE_Q)), "output x beyond one")

endmodule

/* sim/slerp_checker.sv */
// Checker for quaternion_slerp: watches both stream channels, predicts each
// result in fixed point and compares it with what the block delivers.
// Depends on slrp_pkg only.
module slerp_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [279:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,
  output int           fail_count,
  output int           pending_count,
  output int           result_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import slrp_pkg::*;

  localparam int CFRAC = 30;
  localparam int TFRAC = 16;
  localparam longint ONE_Q = 64'sd1 << CFRAC;

  logic [127:0] expected_quats[$];

  // atan(2^-i) in Q.30 radians
  function automatic longint arc_step(int i);
    longint head[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                         33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return head[i];
    return 64'sd1 << (30 - i);
  endfunction

  function automatic longint clamp_one(longint v);
    if (v > ONE_Q) return ONE_Q;
    if (v < -ONE_Q) return -ONE_Q;
    return v;
  endfunction

  function automatic longint root_floor(longint unsigned r);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > r) b = b >> 2;
    while (b != 0) begin
      if (r >= res + b) begin
        r = r - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  // vectoring CORDIC: angle of (x, y)
  function automatic longint arc_angle(longint x, longint y);
    longint z, nx, ny;
    z = 0;
    for (int i = 0; i < 30; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += arc_step(i);
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= arc_step(i);
      end
      x = nx; y = ny;
    end
    return z;
  endfunction

  // rotation CORDIC: sine clamped to [0, 1.0]
  function automatic longint arc_sine(longint z);
    longint x, y, nx, ny;
    x = 652032874; y = 0;
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= arc_step(i);
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += arc_step(i);
      end
      x = nx; y = ny;
    end
    if (y < 0) y = 0;
    if (y > (64'sd1 << 30)) y = 64'sd1 << 30;
    return y;
  endfunction

  function automatic logic [127:0] slerp_predict(logic [279:0] d);
    longint src[4], dst[4];
    longint dot, adot, sinth, theta, a0, a1, s0, s1, num, p;
    longint unsigned tf;
    logic [127:0] r;
    dot = 0;
    for (int k = 0; k < 4; k++) begin
      src[k] = longint'($signed(d[32*k +: 32]));
      dst[k] = longint'($signed(d[128 + 32*k +: 32]));
      p = src[k] * dst[k];
      dot += p >>> CFRAC;
    end
    adot = dot < 0 ? -dot : dot;
    if (adot > ONE_Q) adot = ONE_Q;
    sinth = root_floor((64'd1 << 60) - longint'(adot) * longint'(adot));
    if (adot >= ONE_Q - 1 || sinth == 0) begin
      for (int k = 0; k < 4; k++) r[32*k +: 32] = 32'(clamp_one(src[k]));
      return r;
    end
    theta = arc_angle(adot, sinth);
    if (theta < 0) theta = 0;
    tf = d[256 +: 17];
    if (tf > (64'd1 << TFRAC)) tf = 64'd1 << TFRAC;
    a1 = longint'((longint'(theta) * tf) >> TFRAC);
    a0 = theta - a1;
    s0 = arc_sine(a0);
    s1 = arc_sine(a1);
    if (dot < 0) s1 = -s1;
    for (int k = 0; k < 4; k++) begin
      num = src[k] * s0 + dst[k] * s1;
      r[32*k +: 32] = 32'(clamp_one(num / sinth));
    end
    return r;
  endfunction

  assign pending_count = expected_quats.size();

  // queue an expectation per input transfer, compare each output transfer
  always @(posedge clk) begin
    logic [127:0] want;
    if (rst_n && in_tvalid && in_tready) expected_quats.push_back(slerp_predict(in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      result_count++;
      if (expected_quats.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result %h", $time, out_tdata);
      end else begin
        want = expected_quats.pop_front();
        for (int k = 0; k < 4; k++)
          if (want[32*k +: 32] !== out_tdata[32*k +: 32]) begin
            fail_count++;
            $display("%0t: component %0d expected %h actual %h", $time, k,
                     want[32*k +: 32], out_tdata[32*k +: 32]);
          end
      end
    end
  end

  initial begin
    fail_count = 0;
    result_count = 0;
  end
endmodule

/* sim/tb_top.sv */
// Testbench top for quaternion_slerp: makes directed and random slerp
// requests, random stalls on both sides, and reports the verdict.
// Depends on quaternion_slerp, slerp_checker and slrp_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE = 1 << 30;
  localparam int IDLE_LIMIT = 5000;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [279:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [127:0] out_tdata;
  int           fail_count, pending_count, result_count;
  int           item_count = 0;
  int           idle_cycles = 0;
  bit           hold_off = 0;

  always #6 clk = ~clk;

  quaternion_slerp i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  slerp_checker i_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // random quaternion: raw bits, or components in [-1.0, 1.0], sometimes halved
  function automatic logic [127:0] rand_quat();
    logic [127:0] q;
    int mode;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 4; k++) begin
      if (mode == 0) q[32*k +: 32] = $urandom();          // raw noise, any bits
      else q[32*k +: 32] = $urandom_range(0, 2*ONE) - ONE;
    end
    if (mode >= 1 && mode <= 5) begin
      // roughly normalized: halve every component to shrink the norm
      for (int k = 0; k < 4; k++) q[32*k +: 32] = $signed(q[32*k +: 32]) >>> 1;
    end
    return q;
  endfunction

  function automatic logic [279:0] pack_req(logic [127:0] a, logic [127:0] b,
                                            logic [16:0] t);
    return {7'd0, t, b, a};
  endfunction

  function automatic logic [127:0] quat(int x, int y, int z, int w);
    return {w, z, y, x};
  endfunction

  task automatic send(logic [279:0] d);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    item_count++;
  endtask

  // receiver: random stalls, one long hold-off while items keep coming
  initial begin
    int g;
    @(posedge rst_n);
    while (1) begin
      if (hold_off) begin
        out_tready <= 0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      g = gap_len();
      out_tready <= (g == 0);
      @(posedge clk);
      if (g > 1) repeat (g - 1) @(posedge clk);
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_count);
      $display("quaternion_slerp test failed");
      $finish;
    end
  end

  initial begin
    logic [127:0] a, b, c;
    logic [16:0] t;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: identity, opposite, orthogonal, extremes of t, raw limits
    a = quat(0, 0, 0, ONE);
    b = quat(0, 0, ONE, 0);
    c = quat(ONE / 2, ONE / 2, ONE / 2, ONE / 2);
    send(pack_req(a, a, 17'd32768));                      // equal
    send(pack_req(a, quat(0, 0, 0, -ONE), 17'd32768));    // equal via sign
    send(pack_req(a, quat(0, 0, 0, ONE - 1), 17'd32768)); // within one LSB
    send(pack_req(a, b, 17'd0));
    send(pack_req(a, b, 17'd65536));
    send(pack_req(a, b, 17'd32768));
    send(pack_req(a, b, 17'h1FFFF));                      // t above one
    send(pack_req(a, c, 17'd16384));
    send(pack_req(a, quat(0, 0, -ONE / 2, -ONE / 2), 17'd40000)); // negative dot
    send(pack_req(c, quat(-ONE, 0, 0, 0), 17'd1));
    send(pack_req(quat(-ONE, -ONE, -ONE, -ONE), quat(ONE, ONE, ONE, ONE), 17'd30000));
    send(pack_req({4{32'h7FFFFFFF}}, {4{32'h80000000}}, 17'd65535));
    send(pack_req({4{32'h80000000}}, {4{32'h7FFFFFFF}}, 17'd12345));
    send(pack_req({4{32'hFFFFFFFF}}, {4{32'h00000001}}, 17'd50000));
    send(pack_req(a, quat(0, 0, 1000, ONE - 1), 17'd20000)); // tiny angle
    send(pack_req('0, '0, 17'd100));
    // random, with the long receiver hold-off partway through
    for (int n = 0; n < 1350; n++) begin
      if (n == 300) hold_off = 1;
      a = rand_quat();
      case ($urandom_range(0, 5))
        0: b = a;
        1: b = a ^ 128'($urandom_range(0, 3));
        default: b = rand_quat();
      endcase
      case ($urandom_range(0, 5))
        0: t = $urandom();
        1: t = $urandom_range(0, 1) ? 17'd0 : 17'd65536;
        default: t = $urandom_range(0, 65536);
      endcase
      send(pack_req(a, b, t));
    end
    in_tvalid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d slerp requests, checked %0d results", item_count, result_count);
    $display("covered nearly-equal, opposite-sign, t extremes and long output stall");
    if (fail_count == 0) $display("quaternion_slerp test passed");
    else $display("quaternion_slerp test failed");
    $finish;
  end
endmodule
